/* design/tspid_pkg.sv */
// Shared types, codes and constants for the transport stream header and PID checker.
`default_nettype none

package tspid_pkg;

	localparam int PID_ENTRIES = 8192;
	localparam int ADDR_W      = $clog2(PID_ENTRIES);
	localparam int PID_W       = 13;
	localparam int ENTRY_W     = 10;
	localparam int PB_W        = 8;

	localparam logic [PID_W-1:0] NULL_PID  = 13'h1fff;
	localparam logic [7:0]       SYNC_CODE = 8'h47;
	localparam logic [PB_W-1:0]  PB_RESET  = 8'd188;

	// Entry layout
	localparam int E_REG  = 0;
	localparam int E_PES  = 1;
	localparam int E_STRM = 2;
	localparam int E_WAIT = 3;
	localparam int E_CCV  = 4;
	localparam int E_DATA = 5;
	localparam int E_CC_LO = 6;
	localparam int E_CC_HI = 9;

	// Command codes
	localparam logic [1:0] FUNC_HEADER    = 2'd0;
	localparam logic [1:0] FUNC_REGISTER  = 2'd1;
	localparam logic [1:0] FUNC_REMOVE    = 2'd2;
	localparam logic [1:0] FUNC_STREAMING = 2'd3;

	// Status codes
	localparam logic [2:0] STATUS_CONTINUE = 3'd0;
	localparam logic [2:0] STATUS_STREAM   = 3'd1;
	localparam logic [2:0] STATUS_DISCONT  = 3'd2;
	localparam logic [2:0] STATUS_NO_SYNC  = 3'd3;
	localparam logic [2:0] STATUS_ERROR    = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       sync_byte;
		logic [15:0]      header_word;
		logic [7:0]       flags_byte;
		logic [7:0]       adaptation_length;
		logic [7:0]       adaptation_flags;
		logic [PID_W-1:0] table_pid;
		logic             entry_is_pes;
		logic             streaming_enable;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [PID_W-1:0] pid;
		logic             discontinuity;
		logic             carries_payload;
		logic             unit_start;
		logic [7:0]       payload_offset;
		logic [7:0]       payload_length;
		logic             entry_found;
		logic             entry_is_pes_out;
	} res_t;

endpackage

`default_nettype wire

/* design/tspid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tspid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/tspid_update.sv */
// Header checks, command decode and PID entry read-modify-write update.
`default_nettype none

module tspid_update (
	input  wire tspid_pkg::req_t                     req,
	input  wire logic [tspid_pkg::ENTRY_W-1:0]       rd_entry,
	input  wire logic [tspid_pkg::PB_W-1:0]          packet_bytes,
	output tspid_pkg::res_t                          res,
	output logic                                     wr_en,
	output logic      [tspid_pkg::ENTRY_W-1:0]       wr_entry
);

	logic [tspid_pkg::PID_W-1:0]   pid_w;
	logic                          in_range;
	logic [tspid_pkg::ENTRY_W-1:0] e;
	logic [tspid_pkg::ENTRY_W-1:0] e_new;
	logic                          wr;
	logic                          pus;
	logic                          pay;
	logic                          isd;
	logic                          go;
	logic [3:0]                    cc;
	logic [3:0]                    expect_cc;
	logic [8:0]                    pb9;
	logic [8:0]                    off9;
	logic [8:0]                    plen9;
	logic                          adapt_err;
	logic [tspid_pkg::ENTRY_W-1:0] e_final;

	assign pid_w = (req.func == tspid_pkg::FUNC_HEADER) ? req.header_word[12:0] : req.table_pid;
	assign in_range = {1'b0, pid_w} < (tspid_pkg::PID_W+1)'(tspid_pkg::PID_ENTRIES);

	always_comb begin
		e         = in_range ? rd_entry : '0;
		e_new     = e;
		wr        = 1'b0;
		go        = 1'b0;
		pus       = 1'b0;
		pay       = req.flags_byte[4];
		cc        = req.flags_byte[3:0];
		isd       = req.flags_byte[5] && (req.adaptation_length != 8'd0)
			&& req.adaptation_flags[7];
		pb9       = {1'b0, packet_bytes};
		off9      = req.flags_byte[5] ? ({1'b0, req.adaptation_length} + 9'd5) : 9'd4;
		plen9     = (pay && (pb9 >= off9)) ? (pb9 - off9) : 9'd0;
		adapt_err = req.flags_byte[5] && ((packet_bytes < 8'd5)
			|| ({1'b0, req.adaptation_length} > (pb9 - 9'd5)));
		expect_cc = pay ? (e[tspid_pkg::E_CC_HI:tspid_pkg::E_CC_LO] + 4'd1)
			: e[tspid_pkg::E_CC_HI:tspid_pkg::E_CC_LO];

		res                  = '0;
		res.status           = tspid_pkg::STATUS_CONTINUE;
		res.pid              = pid_w;
		res.payload_offset   = 8'd4;

		case (req.func)
			tspid_pkg::FUNC_REGISTER: begin
				if (!e[tspid_pkg::E_REG]) begin
					e_new = '0;
					e_new[tspid_pkg::E_REG]  = 1'b1;
					e_new[tspid_pkg::E_WAIT] = 1'b1;
				end
				e_new[tspid_pkg::E_PES] = req.entry_is_pes;
				if (req.entry_is_pes) begin
					e_new[tspid_pkg::E_STRM] = 1'b0;
				end
				wr = 1'b1;
			end
			tspid_pkg::FUNC_REMOVE: begin
				e_new = '0;
				wr    = 1'b1;
			end
			tspid_pkg::FUNC_STREAMING: begin
				e_new[tspid_pkg::E_STRM] = req.streaming_enable;
				wr = e[tspid_pkg::E_REG];
			end
			default: begin
				pus = req.header_word[14];
				res.unit_start = pus;
				if (req.sync_byte != tspid_pkg::SYNC_CODE) begin
					res.status = tspid_pkg::STATUS_NO_SYNC;
				end else if (req.header_word[15] || (pid_w == tspid_pkg::NULL_PID)) begin
					res.status = tspid_pkg::STATUS_CONTINUE;
				end else if (adapt_err) begin
					res.status = tspid_pkg::STATUS_ERROR;
				end else begin
					res.payload_offset = off9[7:0];
					res.payload_length = plen9[7:0];
					go = 1'b1;
					if (!e[tspid_pkg::E_REG]) begin
						if ((pid_w == '0) && pus) begin
							e_new = '0;
							e_new[tspid_pkg::E_REG]  = 1'b1;
							e_new[tspid_pkg::E_WAIT] = 1'b1;
							e_new[tspid_pkg::E_CCV]  = 1'b1;
							e_new[tspid_pkg::E_CC_HI:tspid_pkg::E_CC_LO] = cc;
						end else begin
							go = 1'b0;
						end
					end else if (e[tspid_pkg::E_WAIT] && !pus) begin
						// Still waiting for a unit start: track the counter only
						e_new[tspid_pkg::E_CCV] = 1'b1;
						e_new[tspid_pkg::E_CC_HI:tspid_pkg::E_CC_LO] = cc;
						wr = 1'b1;
						res.discontinuity = 1'b1;
						res.status = tspid_pkg::STATUS_DISCONT;
						go = 1'b0;
					end else begin
						if (e[tspid_pkg::E_CCV] && !isd && (expect_cc != cc)) begin
							res.discontinuity = 1'b1;
							if (!pus) begin
								// Counter break: drop back to waiting for a unit start
								e_new = '0;
								e_new[tspid_pkg::E_REG]  = e[tspid_pkg::E_REG];
								e_new[tspid_pkg::E_PES]  = e[tspid_pkg::E_PES];
								e_new[tspid_pkg::E_STRM] = e[tspid_pkg::E_STRM];
								e_new[tspid_pkg::E_WAIT] = 1'b1;
								wr = 1'b1;
								res.status = tspid_pkg::STATUS_DISCONT;
								go = 1'b0;
							end
						end
						if (go) begin
							e_new[tspid_pkg::E_CCV] = 1'b1;
							e_new[tspid_pkg::E_CC_HI:tspid_pkg::E_CC_LO] = cc;
						end
					end
					if (go) begin
						res.discontinuity   = res.discontinuity | isd;
						res.carries_payload = pay;
						if (pus && e_new[tspid_pkg::E_STRM] && e_new[tspid_pkg::E_PES]
							&& !e_new[tspid_pkg::E_WAIT]) begin
							e_new[tspid_pkg::E_DATA] = 1'b1;
							res.status = tspid_pkg::STATUS_STREAM;
						end
						if (pus && pay && (plen9 != 9'd0)) begin
							e_new[tspid_pkg::E_WAIT] = 1'b0;
							e_new[tspid_pkg::E_DATA] = 1'b0;
						end
						wr = 1'b1;
					end
				end
			end
		endcase

		wr_en    = wr && in_range;
		wr_entry = e_new;
		e_final  = wr_en ? e_new : e;
		res.entry_found      = e_final[tspid_pkg::E_REG];
		res.entry_is_pes_out = e_final[tspid_pkg::E_REG] && e_final[tspid_pkg::E_PES];
	end

endmodule

`default_nettype wire

/* design/ts_header_pid_continuity_check.sv */
// Top level of the transport stream header checker with PID table and continuity check.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request per handshake: either the
//   first six bytes of a transport packet (func header) or a PID table command
//   (register, remove, set streaming). Output channel (out_valid/out_ready) returns
//   exactly one result per request, in request order.
//   Configuration channel (cfg_valid/cfg_ready) writes packet_bytes; it is always
//   ready and must only be used while no request is in flight.
// Sequence: the table entry of an accepted request is read, then updated and written
//   back in ST_EXEC, and its result is registered into the output register.
//   The PID table is a single 8192 x 10 RAM with registered read; no new request
//   is taken until the write-back is done, so accesses never overlap.
// Reset: packet_bytes returns to 188 and a clearing pass writes every table entry
//   to zero, one per cycle; in_ready stays low until it finishes.
// Stall: the result sits in an output register, so the next request is accepted
//   while a result waits; its update and write-back hold until the output
//   register is free or being taken.
`default_nettype none

module ts_header_pid_continuity_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tspid_pkg::PB_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire logic [7:0]                    sync_byte,
	input  wire logic [15:0]                   header_word,
	input  wire logic [7:0]                    flags_byte,
	input  wire logic [7:0]                    adaptation_length,
	input  wire logic [7:0]                    adaptation_flags,
	input  wire logic [tspid_pkg::PID_W-1:0]   table_pid,
	input  wire logic                          entry_is_pes,
	input  wire logic                          streaming_enable,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [2:0]                    status,
	output logic      [tspid_pkg::PID_W-1:0]   pid,
	output logic                               discontinuity,
	output logic                               carries_payload,
	output logic                               unit_start,
	output logic      [7:0]                    payload_offset,
	output logic      [7:0]                    payload_length,
	output logic                               entry_found,
	output logic                               entry_is_pes_out
);

	tspid_pkg::state_t                state_q;
	tspid_pkg::state_t                state_d;
	logic [tspid_pkg::ADDR_W-1:0]     clr_q;
	logic [tspid_pkg::PB_W-1:0]       packet_bytes_q;
	tspid_pkg::req_t                  req_q;
	tspid_pkg::req_t                  req_in;
	tspid_pkg::res_t                  out_q;
	tspid_pkg::res_t                  upd_res;
	logic                             out_valid_q;
	logic                             in_fire;
	logic                             commit;
	logic                             out_free;
	logic                             ram_we;
	logic [tspid_pkg::ADDR_W-1:0]     ram_waddr;
	logic [tspid_pkg::ENTRY_W-1:0]    ram_wdata;
	logic [tspid_pkg::ADDR_W-1:0]     ram_raddr;
	logic [tspid_pkg::ENTRY_W-1:0]    ram_rdata;
	logic                             upd_we;
	logic [tspid_pkg::ENTRY_W-1:0]    upd_entry;
	logic [tspid_pkg::PID_W-1:0]      in_pid;
	logic [tspid_pkg::PID_W-1:0]      req_pid;

	assign req_in = '{
		func:              func,
		sync_byte:         sync_byte,
		header_word:       header_word,
		flags_byte:        flags_byte,
		adaptation_length: adaptation_length,
		adaptation_flags:  adaptation_flags,
		table_pid:         table_pid,
		entry_is_pes:      entry_is_pes,
		streaming_enable:  streaming_enable
	};

	// Table address of the incoming request and of the one being updated
	assign in_pid  = (func == tspid_pkg::FUNC_HEADER) ? header_word[12:0] : table_pid;
	assign req_pid = (req_q.func == tspid_pkg::FUNC_HEADER) ? req_q.header_word[12:0]
		: req_q.table_pid;
	assign ram_raddr = in_pid[tspid_pkg::ADDR_W-1:0];

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	tspid_ram #(
		.WIDTH(tspid_pkg::ENTRY_W),
		.DEPTH(tspid_pkg::PID_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_fire),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tspid_update u_update (
		.req         (req_q),
		.rd_entry    (ram_rdata),
		.packet_bytes(packet_bytes_q),
		.res         (upd_res),
		.wr_en       (upd_we),
		.wr_entry    (upd_entry)
	);

	// Sequencer: clear pass, lookup, update and write back
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		in_fire   = 1'b0;
		commit    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = req_pid[tspid_pkg::ADDR_W-1:0];
		ram_wdata = upd_entry;
		case (state_q)
			tspid_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == tspid_pkg::ADDR_W'(tspid_pkg::PID_ENTRIES - 1)) begin
					state_d = tspid_pkg::ST_IDLE;
				end
			end
			tspid_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				in_fire  = in_valid;
				if (in_valid) begin
					state_d = tspid_pkg::ST_EXEC;
				end
			end
			tspid_pkg::ST_EXEC: begin
				if (out_free) begin
					commit  = 1'b1;
					ram_we  = upd_we;
					state_d = tspid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tspid_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tspid_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the clear pointer during the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == tspid_pkg::ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_bytes_q <= tspid_pkg::PB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			packet_bytes_q <= cfg_data;
		end
	end

	// Hold the accepted request for the update cycle
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= upd_res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign pid              = out_q.pid;
	assign discontinuity    = out_q.discontinuity;
	assign carries_payload  = out_q.carries_payload;
	assign unit_start       = out_q.unit_start;
	assign payload_offset   = out_q.payload_offset;
	assign payload_length   = out_q.payload_length;
	assign entry_found      = out_q.entry_found;
	assign entry_is_pes_out = out_q.entry_is_pes_out;

endmodule

`default_nettype wire

/* design/tspid_checker.sv */
// Port-level checks for the transport stream header checker, bound to the top level.
`default_nettype none

module tspid_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [2:0]                  status,
	input wire logic [tspid_pkg::PID_W-1:0] pid,
	input wire logic                        carries_payload,
	input wire logic                        unit_start,
	input wire logic [7:0]                  payload_offset,
	input wire logic [7:0]                  payload_length,
	input wire logic                        entry_found,
	input wire logic                        entry_is_pes_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pid)
			&& $stable(payload_length))
		else $error("result changed while stalled");

	a_pes_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_is_pes_out |-> entry_found)
		else $error("PES type reported without an entry");

	a_stream_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tspid_pkg::STATUS_STREAM)
			|-> unit_start && entry_found && entry_is_pes_out)
		else $error("stream start without a registered PES unit start");

	a_rejected_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == tspid_pkg::STATUS_NO_SYNC)
			|| (status == tspid_pkg::STATUS_ERROR))
			|-> (payload_offset == 8'd4) && (payload_length == 8'd0) && !carries_payload)
		else $error("rejected packet reports payload");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= tspid_pkg::STATUS_ERROR)
		else $error("status code out of range");

endmodule

bind ts_header_pid_continuity_check tspid_checker u_tspid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.pid             (pid),
	.carries_payload (carries_payload),
	.unit_start      (unit_start),
	.payload_offset  (payload_offset),
	.payload_length  (payload_length),
	.entry_found     (entry_found),
	.entry_is_pes_out(entry_is_pes_out)
);

`default_nettype wire
